// ===== src/taq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package taq_pkg;

   localparam int SLOTS_DEF    = 16;
   localparam int ACTION_W     = 2;
   localparam int SLOT_FIELD_W = 4;
   localparam int TICK_W       = 64;
   localparam int DELAY_W      = 32;
   localparam int COUNT_W      = 16;
   localparam int STAMP_W      = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK   = 2'd0,
      ACT_CREATE = 2'd1,
      ACT_CANCEL = 2'd2
   } action_type;

   localparam logic ST_OK   = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   // one alarm slot as stored in the entry memory
   typedef struct packed {
      logic [TICK_W-1:0]  deadline;
      logic [DELAY_W-1:0] period;
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // status of the due-alarm search
   typedef struct packed {
      logic done;
      logic found;
   } pick_stat_type;

endpackage

`default_nettype wire

// ===== src/taq_entry_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module taq_entry_ram #(
   parameter int DEPTH = taq_pkg::SLOTS_DEF,
   parameter int AW    = $clog2(taq_pkg::SLOTS_DEF)
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [AW-1:0]             wr_addr,
   input  taq_pkg::entry_type       wr_data,
   input  wire                      rd_en,
   input  wire [AW-1:0]             rd_addr,
   output taq_pkg::entry_type       rd_data
);

   taq_pkg::entry_type mem [DEPTH];
   taq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/taq_pick.sv =====
`timescale 1ns / 1ps
`default_nettype none

module taq_pick #(
   parameter int SLOTS = taq_pkg::SLOTS_DEF,
   parameter int AW    = $clog2(taq_pkg::SLOTS_DEF)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [taq_pkg::TICK_W-1:0]    elapsed,
   input  wire [SLOTS-1:0]              slot_valid,
   output logic                         rd_en,
   output logic [AW-1:0]                rd_addr,
   input  taq_pkg::entry_type           rd_data,
   output taq_pkg::pick_stat_type       stat,
   output logic [AW-1:0]                best_idx,
   output taq_pkg::entry_type           best_entry
);

   logic [AW:0]        cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               found_ff, found_in;
   logic               rd_vld_ff;
   logic [AW-1:0]      rd_idx_ff;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   taq_pkg::entry_type best_ff, best_in;
   logic               last_cmp;
   logic               cand;
   logic               better;

   assign rd_en    = busy_ff && (cnt_ff != (AW+1)'(SLOTS));
   assign rd_addr  = cnt_ff[AW-1:0];
   assign last_cmp = busy_ff && (cnt_ff == (AW+1)'(SLOTS));

   // candidate is armed and due; better is earlier deadline, then earlier stamp
   assign cand   = rd_vld_ff && (rd_data.deadline <= elapsed);
   assign better = !found_ff || (rd_data.deadline < best_ff.deadline) ||
                   ((rd_data.deadline == best_ff.deadline) &&
                    (rd_data.stamp < best_ff.stamp));

   always_comb begin
      cnt_in      = cnt_ff;
      busy_in     = busy_ff;
      done_in     = done_ff;
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      if (rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cand && better) begin
         found_in    = 1'b1;
         best_idx_in = rd_idx_ff;
         best_in     = rd_data;
      end
      if (last_cmp) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
      if (start) begin
         cnt_in   = '0;
         busy_in  = 1'b1;
         done_in  = 1'b0;
         found_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         found_ff  <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         busy_ff   <= busy_in;
         done_ff   <= done_in;
         found_ff  <= found_in;
         rd_vld_ff <= rd_en && slot_valid[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_addr;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
   end

   assign stat.done  = done_ff;
   assign stat.found = found_ff;
   assign best_idx   = best_idx_ff;
   assign best_entry = best_ff;

endmodule

`default_nettype wire

// ===== src/tick_alarm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | handshake          | payload
// ---------+-----+--------------------+----------------------------------------------
// req      | in  | req_tvalid/tready  | tuser: action; tdata: slot, delay, repeat
// rsp      | out | rsp_tvalid/tready  | tuser: fired, status; tdata: fired_slot
//
// create, cancel and unused actions finish in the accept cycle
// a tick walks the entry memory one slot a cycle, taking no new item until it commits;
//   the rate is set by the single read port of the entry memory
// reset clears the valid flags, elapsed tick count and stamp counter; no clearing pass
// the result sits in an output register; a new item is taken once it is free or leaving
// a stalled result holds the tick commit until the output register frees up

module tick_alarm_queue #(
   parameter int SLOTS = taq_pkg::SLOTS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [55:0] req_tdata,   // [3:0] slot, [35:4] delay_ticks, [51:36] repeat_count
   input  wire [1:0]  req_tuser,   // [1:0] action
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [3:0] fired_slot
   output logic [1:0] rsp_tuser    // [0] fired, [1] status
);

   localparam int AW = $clog2(SLOTS);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // request fields
   logic [taq_pkg::SLOT_FIELD_W-1:0] req_slot;
   logic [taq_pkg::DELAY_W-1:0]      req_delay;
   logic [taq_pkg::COUNT_W-1:0]      req_repeat;
   taq_pkg::action_type              req_action;
   logic [AW-1:0]                    slot_idx;
   logic                             slot_ok;
   logic                             req_acc;

   // block state
   logic [taq_pkg::TICK_W-1:0]  elapsed_ff, elapsed_in;
   logic [taq_pkg::STAMP_W-1:0] stamp_ff, stamp_in;
   logic [SLOTS-1:0]            valid_ff, valid_in;

   // output register
   logic                             rsp_valid_ff;
   logic [taq_pkg::SLOT_FIELD_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                             rsp_fired_ff, rsp_fired_in;
   logic                             rsp_status_ff, rsp_status_in;
   logic                             out_free;
   logic                             load;

   // memory ports
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   taq_pkg::entry_type wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   taq_pkg::entry_type rd_data;

   // search unit
   logic                   pick_start;
   taq_pkg::pick_stat_type pick_stat;
   logic [AW-1:0]          best_idx;
   taq_pkg::entry_type     best_entry;

   assign req_slot   = req_tdata[3:0];
   assign req_delay  = req_tdata[35:4];
   assign req_repeat = req_tdata[51:36];
   assign req_action = taq_pkg::action_type'(req_tuser);
   assign slot_idx   = AW'(req_slot);
   assign slot_ok    = 32'(req_slot) < 32'(SLOTS);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_acc    = req_tvalid && req_tready;

   taq_entry_ram #(
      .DEPTH (SLOTS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   taq_pick #(
      .SLOTS (SLOTS),
      .AW    (AW)
   ) u_pick (
      .clock      (clock),
      .reset      (reset),
      .start      (pick_start),
      .elapsed    (elapsed_ff),
      .slot_valid (valid_ff),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .stat       (pick_stat),
      .best_idx   (best_idx),
      .best_entry (best_entry)
   );

   always_comb begin
      state_in      = state_ff;
      elapsed_in    = elapsed_ff;
      stamp_in      = stamp_ff;
      valid_in      = valid_ff;
      load          = 1'b0;
      rsp_slot_in   = '0;
      rsp_fired_in  = 1'b0;
      rsp_status_in = taq_pkg::ST_OK;
      wr_en         = 1'b0;
      wr_addr       = slot_idx;
      wr_data       = '0;
      pick_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               case (req_action)
                  taq_pkg::ACT_TICK: begin
                     elapsed_in = elapsed_ff + 1'b1;
                     pick_start = 1'b1;
                     state_in   = S_SCAN;
                  end
                  taq_pkg::ACT_CREATE: begin
                     load = 1'b1;
                     if (!slot_ok || valid_ff[slot_idx]) begin
                        rsp_status_in = taq_pkg::ST_BUSY;
                     end else if (req_delay == '0) begin
                        // zero period fires at once and stores nothing
                        rsp_fired_in = 1'b1;
                        rsp_slot_in  = req_slot;
                     end else begin
                        wr_en            = 1'b1;
                        wr_data.deadline = elapsed_ff + 64'(req_delay);
                        wr_data.period   = req_delay;
                        wr_data.count    = req_repeat;
                        wr_data.stamp    = stamp_ff;
                        stamp_in         = stamp_ff + 1'b1;
                        valid_in[slot_idx] = 1'b1;
                     end
                  end
                  taq_pkg::ACT_CANCEL: begin
                     load = 1'b1;
                     if (slot_ok) begin
                        valid_in[slot_idx] = 1'b0;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // commit once the search is over and the output register can take the item
            if (pick_stat.done && out_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
               if (pick_stat.found) begin
                  rsp_fired_in = 1'b1;
                  rsp_slot_in  = 4'(best_idx);
                  if (best_entry.count == 16'd1) begin
                     // last firing of a finite alarm
                     valid_in[best_idx] = 1'b0;
                  end else begin
                     wr_en            = 1'b1;
                     wr_addr          = best_idx;
                     wr_data.deadline = elapsed_ff + 64'(best_entry.period);
                     wr_data.period   = best_entry.period;
                     wr_data.count    = (best_entry.count == '0) ? '0
                                        : best_entry.count - 1'b1;
                     wr_data.stamp    = stamp_ff;
                     stamp_in         = stamp_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         elapsed_ff   <= '0;
         stamp_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         elapsed_ff <= elapsed_in;
         stamp_ff   <= stamp_in;
         valid_ff   <= valid_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_slot_ff   <= rsp_slot_in;
         rsp_fired_ff  <= rsp_fired_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_slot_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_fired_ff};

endmodule

`default_nettype wire

// ===== bench/taq_checker.sv =====
`timescale 1ns / 1ps

module taq_checker #(
   parameter int SLOTS = taq_pkg::SLOTS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   input  wire        req_tready,
   input  wire [55:0] req_tdata,   // [3:0] slot, [35:4] delay_ticks, [51:36] repeat_count
   input  wire [1:0]  req_tuser,   // [1:0] action
   input  wire        rsp_tvalid,
   input  wire        rsp_tready,
   input  wire [7:0]  rsp_tdata,   // [3:0] fired_slot
   input  wire [1:0]  rsp_tuser,   // [0] fired, [1] status
   output int         error_count,
   output int         pending_count
);

   typedef struct packed {
      logic                             fired;
      logic [taq_pkg::SLOT_FIELD_W-1:0] slot;
      logic                             status;
   } alarm_event_type;

   // shadow alarm table
   logic [taq_pkg::TICK_W-1:0]  elapsed;
   logic                        armed      [SLOTS];
   logic [taq_pkg::TICK_W-1:0]  due_at     [SLOTS];
   logic [taq_pkg::DELAY_W-1:0] reload     [SLOTS];
   logic [taq_pkg::COUNT_W-1:0] shots_left [SLOTS];
   logic [taq_pkg::STAMP_W-1:0] order_tag  [SLOTS];
   logic [taq_pkg::STAMP_W-1:0] tag_next;

   alarm_event_type due_events [$];

   task automatic arm_alarm(input int s, input logic [taq_pkg::DELAY_W-1:0] ticks);
      due_at[s]    = elapsed + ticks;
      order_tag[s] = tag_next;
      tag_next     = tag_next + 1'b1;
      armed[s]     = 1'b1;
   endtask

   // advance time and fire the earliest due alarm, oldest insertion on a tie
   task automatic run_tick(output alarm_event_type ev);
      int best;
      bit found;
      best    = 0;
      found   = 1'b0;
      ev      = '0;
      elapsed = elapsed + 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
         if (armed[i] && due_at[i] <= elapsed &&
             (!found || due_at[i] < due_at[best] ||
              (due_at[i] == due_at[best] && order_tag[i] < order_tag[best]))) begin
            best  = i;
            found = 1'b1;
         end
      end
      if (found) begin
         ev.fired = 1'b1;
         ev.slot  = taq_pkg::SLOT_FIELD_W'(best);
         if (shots_left[best] == '0) begin
            arm_alarm(best, reload[best]);
         end else if (shots_left[best] == taq_pkg::COUNT_W'(1)) begin
            shots_left[best] = '0;
            armed[best]      = 1'b0;
         end else begin
            shots_left[best] = shots_left[best] - 1'b1;
            arm_alarm(best, reload[best]);
         end
      end
   endtask

   task automatic predict_item(input logic [taq_pkg::ACTION_W-1:0] act,
                               input logic [taq_pkg::SLOT_FIELD_W-1:0] s,
                               input logic [taq_pkg::DELAY_W-1:0] ticks,
                               input logic [taq_pkg::COUNT_W-1:0] times);
      alarm_event_type ev;
      ev = '0;
      case (act)
         taq_pkg::ACT_TICK: begin
            run_tick(ev);
         end
         taq_pkg::ACT_CREATE: begin
            if (armed[s]) begin
               ev.status = taq_pkg::ST_BUSY;
            end else if (ticks == '0) begin
               ev.fired = 1'b1;
               ev.slot  = s;
            end else begin
               reload[s]     = ticks;
               shots_left[s] = times;
               arm_alarm(s, ticks);
            end
         end
         taq_pkg::ACT_CANCEL: begin
            armed[s] = 1'b0;
         end
         default: begin
         end
      endcase
      due_events.push_back(ev);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      alarm_event_type got;
      alarm_event_type want;
      if (reset) begin
         elapsed  = '0;
         tag_next = '0;
         for (int i = 0; i < SLOTS; i++) armed[i] = 1'b0;
         due_events.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.fired  = rsp_tuser[0];
            got.slot   = rsp_tdata[3:0];
            got.status = rsp_tuser[1];
            if (due_events.size() == 0) begin
               $error("unexpected result: fired %0d, fired_slot %0d, status %0d",
                      got.fired, got.slot, got.status);
               error_count++;
            end else begin
               want = due_events.pop_front();
               check_field("fired", want.fired, got.fired);
               check_field("fired_slot", want.slot, got.slot);
               check_field("status", want.status, got.status);
            end
         end
         if (req_tvalid && req_tready)
            predict_item(req_tuser, req_tdata[3:0], req_tdata[35:4], req_tdata[51:36]);
      end
      pending_count = due_events.size();
   end

endmodule

// ===== bench/tick_alarm_queue_tb.sv =====
`timescale 1ns / 1ps

module tick_alarm_queue_tb;

   // action code the block must treat as a no-op
   localparam logic [taq_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // generous bound: a tick walks all slots, plus sender gaps and receiver stalls
   localparam int CYCLE_LIMIT = 400_000;
   localparam int TAIL_CYCLES = 2 * taq_pkg::SLOTS_DEF + 8;
   localparam int RANDOM_ITEMS = 700;
   localparam int HOLD_AFTER = 250;   // items sent before the long receiver hold-off
   localparam int HOLD_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;    // [3:0] slot, [35:4] delay_ticks, [51:36] repeat_count
   logic [1:0]  req_tuser;    // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // [3:0] fired_slot
   logic [1:0]  rsp_tuser;    // [0] fired, [1] status

   int error_count;
   int pending_count;
   int sent_items;
   int burst_left;

   tick_alarm_queue #(
      .SLOTS(taq_pkg::SLOTS_DEF)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // watches both channels, predicts every item and scores the results
   taq_checker #(
      .SLOTS(taq_pkg::SLOTS_DEF)
   ) i_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // one item: drive on the falling edge, hold until taken at a rising edge
   task automatic send_item(input logic [taq_pkg::ACTION_W-1:0] act,
                            input logic [taq_pkg::SLOT_FIELD_W-1:0] s,
                            input logic [taq_pkg::DELAY_W-1:0] ticks,
                            input logic [taq_pkg::COUNT_W-1:0] times);
      @(negedge clock);
      req_tuser  = act;
      req_tdata  = {4'b0, times, ticks, s};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   // sender runs in bursts; between bursts valid drops for a random gap,
   // and some bursts follow straight on with no gap at all
   task automatic send_paced(input logic [taq_pkg::ACTION_W-1:0] act,
                             input logic [taq_pkg::SLOT_FIELD_W-1:0] s,
                             input logic [taq_pkg::DELAY_W-1:0] ticks,
                             input logic [taq_pkg::COUNT_W-1:0] times);
      if (burst_left == 0) begin
         if ($urandom_range(3) != 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      send_item(act, s, ticks, times);
   endtask

   // random item mix: half ticks, the rest creates, cancels and a few no-ops;
   // fields the action ignores still carry random bits
   task automatic send_random_item();
      logic [taq_pkg::ACTION_W-1:0]     act;
      logic [taq_pkg::SLOT_FIELD_W-1:0] s;
      logic [taq_pkg::DELAY_W-1:0]      ticks;
      logic [taq_pkg::COUNT_W-1:0]      times;
      int pick;
      pick  = $urandom_range(99);
      s     = taq_pkg::SLOT_FIELD_W'($urandom);
      ticks = $urandom;
      times = taq_pkg::COUNT_W'($urandom);
      if (pick < 50) begin
         act = taq_pkg::ACT_TICK;
      end else if (pick < 80) begin
         act = taq_pkg::ACT_CREATE;
         // mostly short periods so alarms actually come due
         case ($urandom_range(9))
            0:       ticks = '0;
            1:       ticks = $urandom;
            default: ticks = $urandom_range(1, 12);
         endcase
         // forever, a random count, or a few shots
         case ($urandom_range(9))
            0, 1:    times = '0;
            2:       times = taq_pkg::COUNT_W'($urandom);
            default: times = taq_pkg::COUNT_W'($urandom_range(1, 5));
         endcase
      end else if (pick < 95) begin
         act = taq_pkg::ACT_CANCEL;
      end else begin
         act = ACT_UNUSED;
      end
      send_paced(act, s, ticks, times);
   endtask

   // receiver: changes its stall pattern after each random run length, and once
   // holds off for a long stretch so the output register fills and input stalls
   initial begin : sink
      int mode;
      int len;
      bit held;
      held       = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         mode = $urandom_range(3);
         len  = $urandom_range(10, 60);
         for (int k = 0; k < len; k++) begin
            @(negedge clock);
            if (!held && sent_items >= HOLD_AFTER) begin
               held       = 1'b1;
               rsp_tready = 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
            end
            case (mode)
               0:       rsp_tready = 1'b1;
               1:       rsp_tready = 1'($urandom_range(1));
               2:       rsp_tready = (k % 4 == 0);
               default: rsp_tready = ($urandom_range(3) == 0);
            endcase
         end
      end
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      sent_items = 0;
      burst_left = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero period fires at once and stores nothing
      send_paced(taq_pkg::ACT_CREATE, 4'd0, 32'd0, 16'd5);
      // widest period and count, parks the top slot
      send_paced(taq_pkg::ACT_CREATE, 4'd15, 32'hFFFF_FFFF, 16'hFFFF);
      // busy slot rejects, even with a zero period
      send_paced(taq_pkg::ACT_CREATE, 4'd15, 32'd0, 16'd1);
      send_paced(taq_pkg::ACT_CREATE, 4'd15, 32'd3, 16'd0);
      // cancel a busy slot, then the same slot again once it is free
      send_paced(taq_pkg::ACT_CANCEL, 4'd15, 32'd0, 16'd0);
      send_paced(taq_pkg::ACT_CANCEL, 4'd15, 32'd0, 16'd0);
      // two single/double shots due on the same tick: earlier insertion wins
      send_paced(taq_pkg::ACT_CREATE, 4'd3, 32'd2, 16'd1);
      send_paced(taq_pkg::ACT_CREATE, 4'd1, 32'd2, 16'd2);
      // forever alarm every tick, competes with the tie above
      send_paced(taq_pkg::ACT_CREATE, 4'd7, 32'd1, 16'd0);
      // unused action code with every field bit set
      send_paced(ACT_UNUSED, 4'd15, 32'hFFFF_FFFF, 16'hFFFF);
      repeat (6) send_paced(taq_pkg::ACT_TICK, 4'd0, 32'd0, 16'd0);
      send_paced(taq_pkg::ACT_CANCEL, 4'd7, 32'd0, 16'd0);
      send_paced(taq_pkg::ACT_CANCEL, 4'd1, 32'd0, 16'd0);
      // tick with nothing due
      send_paced(taq_pkg::ACT_TICK, 4'd0, 32'd0, 16'd0);
      send_paced(taq_pkg::ACT_CREATE, 4'd2, 32'h8000_0000, 16'h8000);
      send_paced(taq_pkg::ACT_CANCEL, 4'd2, 32'd0, 16'd0);

      repeat (RANDOM_ITEMS) send_random_item();

      @(negedge clock);
      req_tvalid = 1'b0;

      // drain, then give a stray result time to show up
      while (pending_count != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
